/* hw/rtl/mexc_pkg.sv */
// Shared widths, constants and control types for the modexp compute-cost block.
package mexc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 10;
	localparam int unsigned MSB_W  = 3;
	localparam int unsigned COST_W = 22;
	localparam int unsigned FAC_W  = LEN_W + MSB_W;   // adjusted exponent length
	localparam int unsigned SQ_W   = 2 * LEN_W;       // square of the longer operand
	localparam int unsigned MC_W   = 19;              // multiplication complexity
	localparam int unsigned PROD_W = MC_W + FAC_W;    // complexity times factor
	localparam int unsigned NUM_W  = PROD_W + 1;      // dividend incl. rounding term
	localparam int unsigned DVSR_W = 8;               // divisor width
	localparam int unsigned RCP_HALF = 17;            // reciprocal slice used per step
	localparam int unsigned RCP_W  = 2 * RCP_HALF;    // scaled reciprocal of the divisor
	localparam int unsigned RCP_SH = 41;              // reciprocal scale is 2^41
	localparam int unsigned PART_W = NUM_W + RCP_HALF; // one partial product
	localparam int unsigned ACC_W  = NUM_W + RCP_W;   // dividend times reciprocal
	localparam int unsigned QUO_W  = ACC_W - RCP_SH;  // quotient
	localparam int unsigned DIV_STEPS = 2;            // high slice, then low slice
	localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

	localparam logic [LEN_W-1:0]  MAX_BYTES     = 10'd512;
	localparam logic [LEN_W-1:0]  POS_MAX       = 10'd1023;
	localparam logic [LEN_W-1:0]  TOP_WINDOW    = 10'd32;
	localparam logic [LEN_W-1:0]  SMALL_LEN_MAX = 10'd64;
	localparam logic [MC_W-1:0]   MC_LIN        = 19'd96;
	localparam logic [MC_W-1:0]   MC_OFS        = 19'd3072;
	localparam logic [FAC_W-1:0]  MIN_EXP_LEN   = 13'd75;
	localparam logic [FAC_W-1:0]  ONE_FACTOR    = 13'd15;
	localparam logic [DVSR_W-1:0] UNIT_DIVISOR  = 8'd189;
	localparam logic [NUM_W-1:0]  ROUND_UP      = NUM_W'(UNIT_DIVISOR - 8'd1);
	// ceil(2^41 / 189): exact floor quotient for every dividend below 2^33
	localparam logic [RCP_W-1:0]    RECIP       = 34'd11635043681;
	localparam logic [RCP_HALF-1:0] RECIP_HI    = RECIP[RCP_W-1:RCP_HALF];
	localparam logic [RCP_HALF-1:0] RECIP_LO    = RECIP[RCP_HALF-1:0];
	localparam logic [QUO_W:0]    BASE_UNITS    = 27'd422;
	localparam logic [COST_W-1:0] COST_MAX      = 22'h3FFFFF;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SQ   = 6'b000010,
		S_MC   = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic take_beat;   // input beat accepted
		logic take_last;   // accepted beat closes the exponent
		logic do_sq;       // form factor, square, error; clear tracker
		logic do_mc;       // piecewise complexity
		logic do_mul;      // complexity times factor
		logic do_div;      // one reciprocal partial product
		logic load_out;    // write result register
	} cmd_t;

	typedef struct packed {
		logic div_done;    // current division step is the final one
	} sts_t;

endpackage

/* hw/rtl/mexc_ifs.sv */
// Valid/ready channel interfaces for exponent beats and cost results.
interface mexc_in_if;
	logic                         valid;
	logic                         ready;
	logic [mexc_pkg::BYTE_W-1:0]  exponent_byte;
	logic                         byte_present;
	logic                         last_item;
	logic [mexc_pkg::LEN_W-1:0]   exponent_length;
	logic [mexc_pkg::LEN_W-1:0]   base_length;
	logic [mexc_pkg::LEN_W-1:0]   modulus_length;

	modport source (
		output valid, exponent_byte, byte_present, last_item,
		       exponent_length, base_length, modulus_length,
		input  ready
	);
	modport sink (
		input  valid, exponent_byte, byte_present, last_item,
		       exponent_length, base_length, modulus_length,
		output ready
	);
endinterface

interface mexc_out_if;
	logic                         valid;
	logic                         ready;
	logic [mexc_pkg::COST_W-1:0]  compute_cost;
	logic                         length_error;

	modport source (output valid, compute_cost, length_error, input ready);
	modport sink   (input valid, compute_cost, length_error, output ready);
endinterface

/* hw/rtl/mexc_ctrl.sv */
// Sequencer for the cost block: beat intake, arithmetic steps, result handoff.
module mexc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mexc_pkg::cmd_t    cmd,
	input  mexc_pkg::sts_t    sts
);

	mexc_pkg::state_t state_q, state_d;
	logic out_valid_q;

	assign in_ready  = (state_q == mexc_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.take_beat = in_valid && in_ready;
		cmd.take_last = cmd.take_beat && in_last;
		unique case (state_q)
			mexc_pkg::S_IDLE: begin
				if (cmd.take_last) state_d = mexc_pkg::S_SQ;
			end
			mexc_pkg::S_SQ: begin
				cmd.do_sq = 1'b1;
				state_d   = mexc_pkg::S_MC;
			end
			mexc_pkg::S_MC: begin
				cmd.do_mc = 1'b1;
				state_d   = mexc_pkg::S_MUL;
			end
			mexc_pkg::S_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = mexc_pkg::S_DIV;
			end
			mexc_pkg::S_DIV: begin
				cmd.do_div = 1'b1;
				if (sts.div_done) state_d = mexc_pkg::S_DONE;
			end
			mexc_pkg::S_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = mexc_pkg::S_IDLE;
				end
			end
			default: state_d = mexc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before delivery");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_last |=> (state_q == mexc_pkg::S_SQ))
		else $error("last beat did not start cost evaluation");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexc_pkg::S_DIV && sts.div_done) |=> (state_q == mexc_pkg::S_DONE))
		else $error("division did not finish on its final step");

endmodule

/* hw/rtl/mexc_dp.sv */
// Datapath: exponent tracker, complexity arithmetic, reciprocal divider, result register.
module mexc_dp #(
	parameter logic [mexc_pkg::LEN_W-1:0] MAX_BYTES = mexc_pkg::MAX_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mexc_pkg::cmd_t                cmd,
	output mexc_pkg::sts_t                sts,
	input  logic [mexc_pkg::BYTE_W-1:0]   exponent_byte,
	input  logic                          byte_present,
	input  logic [mexc_pkg::LEN_W-1:0]    exponent_length,
	input  logic [mexc_pkg::LEN_W-1:0]    base_length,
	input  logic [mexc_pkg::LEN_W-1:0]    modulus_length,
	output logic [mexc_pkg::COST_W-1:0]   compute_cost,
	output logic                          length_error
);

	function automatic logic [mexc_pkg::MSB_W-1:0] top_bit(input logic [mexc_pkg::BYTE_W-1:0] b);
		logic [mexc_pkg::MSB_W-1:0] k;
		k = '0;
		for (int i = 1; i < mexc_pkg::BYTE_W; i++)
			if (b[i]) k = mexc_pkg::MSB_W'(i);
		return k;
	endfunction

	// exponent tracker
	logic [mexc_pkg::LEN_W-1:0] pos_q, top_pos_q;
	logic [mexc_pkg::MSB_W-1:0] top_msb_q;
	logic                       any_q, eq_one_q;

	// captured lengths and arithmetic registers
	logic [mexc_pkg::LEN_W-1:0]  elen_q, blen_q, mlen_q, maxlen_q;
	logic [mexc_pkg::SQ_W-1:0]   sq_q;
	logic [mexc_pkg::FAC_W-1:0]  factor_q;
	logic                        err_q;
	logic [mexc_pkg::MC_W-1:0]   mc_q;
	logic [mexc_pkg::NUM_W-1:0]  num_q;
	logic [mexc_pkg::ACC_W-1:0]  acc_q;
	logic [mexc_pkg::CNT_W-1:0]  cnt_q;
	logic [mexc_pkg::COST_W-1:0] cost_q;
	logic                        lerr_q;

	logic                          beat_in_range, byte_nz;
	logic [mexc_pkg::LEN_W-1:0]    lo, maxlen;
	logic [mexc_pkg::FAC_W-1:0]    adj, factor_d;
	logic                          err_d;
	logic [mexc_pkg::MC_W-1:0]     mc_d;
	logic [mexc_pkg::PROD_W-1:0]   prod;
	logic [mexc_pkg::RCP_HALF-1:0] rcp_part;
	logic [mexc_pkg::PART_W-1:0]   part;
	logic [mexc_pkg::QUO_W-1:0]    quo;
	logic [mexc_pkg::QUO_W:0]      sum;
	logic [mexc_pkg::COST_W-1:0]   cost_d;

	assign beat_in_range = byte_present && (pos_q < exponent_length);
	assign byte_nz       = (exponent_byte != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			top_pos_q <= '0;
			top_msb_q <= '0;
			any_q     <= 1'b0;
			eq_one_q  <= 1'b0;
		end else if (cmd.do_sq) begin
			pos_q     <= '0;
			top_pos_q <= '0;
			top_msb_q <= '0;
			any_q     <= 1'b0;
			eq_one_q  <= 1'b0;
		end else if (cmd.take_beat && byte_present) begin
			if (beat_in_range) begin
				if (pos_q == '0) eq_one_q <= (exponent_byte == mexc_pkg::BYTE_W'(1));
				else if (byte_nz) eq_one_q <= 1'b0;
				if (byte_nz) begin
					top_pos_q <= pos_q;
					top_msb_q <= top_bit(exponent_byte);
					any_q     <= 1'b1;
				end
			end
			if (pos_q < mexc_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
		end
	end

	// factor: 15 for a unit exponent, else adjusted length floored at 75
	always_comb begin
		lo     = (elen_q > mexc_pkg::TOP_WINDOW) ? (elen_q - mexc_pkg::TOP_WINDOW) : '0;
		maxlen = (blen_q > mlen_q) ? blen_q : mlen_q;
		if (any_q && (top_pos_q >= lo)) adj = {top_pos_q, top_msb_q};
		else adj = {lo, mexc_pkg::MSB_W'(0)};
		if (eq_one_q && (elen_q != '0)) factor_d = mexc_pkg::ONE_FACTOR;
		else if (adj < mexc_pkg::MIN_EXP_LEN) factor_d = mexc_pkg::MIN_EXP_LEN;
		else factor_d = adj;
		err_d = (blen_q > MAX_BYTES) || (elen_q > MAX_BYTES) ||
			(mlen_q > MAX_BYTES) || (mlen_q == '0);
	end

	// lengths stay below 1024, so the x/16 branch of the complexity never applies
	always_comb begin
		if (maxlen_q <= mexc_pkg::SMALL_LEN_MAX) mc_d = mexc_pkg::MC_W'(sq_q);
		else mc_d = mexc_pkg::MC_W'(sq_q >> 2) + mexc_pkg::MC_W'(maxlen_q) * mexc_pkg::MC_LIN
			- mexc_pkg::MC_OFS;
	end

	assign prod  = mexc_pkg::PROD_W'(mc_q) * mexc_pkg::PROD_W'(factor_q);

	// divide by 189: dividend times ceil(2^41/189), high slice first, then shift in low
	assign rcp_part = (cnt_q == '0) ? mexc_pkg::RECIP_HI : mexc_pkg::RECIP_LO;
	assign part     = mexc_pkg::PART_W'(num_q) * mexc_pkg::PART_W'(rcp_part);
	assign quo      = acc_q[mexc_pkg::ACC_W-1:mexc_pkg::RCP_SH];
	assign sum      = {1'b0, quo} + mexc_pkg::BASE_UNITS;
	assign cost_d   = (sum > (mexc_pkg::QUO_W+1)'(mexc_pkg::COST_MAX)) ? mexc_pkg::COST_MAX
		: sum[mexc_pkg::COST_W-1:0];

	assign sts.div_done = (cnt_q == mexc_pkg::CNT_W'(mexc_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.take_last) begin
			elen_q <= exponent_length;
			blen_q <= base_length;
			mlen_q <= modulus_length;
		end
		if (cmd.do_sq) begin
			maxlen_q <= maxlen;
			sq_q     <= mexc_pkg::SQ_W'(maxlen) * mexc_pkg::SQ_W'(maxlen);
			factor_q <= factor_d;
			err_q    <= err_d;
		end
		if (cmd.do_mc) mc_q <= mc_d;
		if (cmd.do_mul) begin
			// ceiling: add divisor - 1 ahead of the division
			num_q <= mexc_pkg::NUM_W'(prod) + mexc_pkg::ROUND_UP;
			acc_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.do_div) begin
			acc_q <= {acc_q[mexc_pkg::ACC_W-1-mexc_pkg::RCP_HALF:0], mexc_pkg::RCP_HALF'(0)}
				+ mexc_pkg::ACC_W'(part);
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			cost_q <= err_q ? '0 : cost_d;
			lerr_q <= err_q;
		end
	end

	assign compute_cost = cost_q;
	assign length_error = lerr_q;

	a_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> ((64'(quo) * 64'(mexc_pkg::UNIT_DIVISOR) <= 64'(num_q)) &&
			(64'(num_q) < 64'(quo) * 64'(mexc_pkg::UNIT_DIVISOR)
				+ 64'(mexc_pkg::UNIT_DIVISOR))))
		else $error("reciprocal divide gave a wrong quotient");

	a_tracker_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sq |=> (pos_q == '0 && !any_q && !eq_one_q))
		else $error("exponent tracker not cleared after last beat");

endmodule

/* hw/rtl/modexp_compute_cost.sv */
// Top level of the modexp compute-cost block: channels, sequencer and datapath.
//
//   channel  dir  payload                                             beat
//   item     in   exponent_byte, byte_present, last_item,             one exponent byte
//                 exponent_length, base_length, modulus_length
//   result   out  compute_cost, length_error                          one cost per exponent
//
// A beat without last_item keeps the sequencer idle, so bytes of one exponent stream at one per cycle.
// A beat with last_item starts the cost evaluation: factor and square, complexity,
// one multiply, then the divide by 189 as a multiply by its scaled reciprocal in two
// 17-bit slices, then the result is written once the result register is free; the
// next item beat is taken after that write.
// The result sits in an output register; a stalled result only holds the block
// once the following exponent's cost is ready to be written.
// arst_n clears the sequencer, the tracker and the result valid; no clearing pass.
module modexp_compute_cost #(
	parameter logic [mexc_pkg::LEN_W-1:0] MAX_BYTES = mexc_pkg::MAX_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	mexc_in_if.sink     item,
	mexc_out_if.source  result
);

	mexc_pkg::cmd_t cmd;
	mexc_pkg::sts_t sts;

	// sequencer: owns both handshakes
	mexc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_last   (item.last_item),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: tracker, arithmetic, divider, result register
	mexc_dp #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.exponent_byte   (item.exponent_byte),
		.byte_present    (item.byte_present),
		.exponent_length (item.exponent_length),
		.base_length     (item.base_length),
		.modulus_length  (item.modulus_length),
		.compute_cost    (result.compute_cost),
		.length_error    (result.length_error)
	);

endmodule
